// ===== rtl/ensc_pkg.sv =====
// ----------------------------------------------------------------------------
// ensc_pkg: shared types, constants and helpers
// Calibration record, sideband beat fields and signed 32-bit constants used
// across the compensation pipeline.
// ----------------------------------------------------------------------------
package ensc_pkg;

  typedef logic signed [31:0] s32_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_C = 3'd3,
    REG_HUM     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [47:0] press_a;
    logic [47:0] press_b;
    logic [47:0] press_c;
    logic [63:0] hum;
  } calib_t;

  // Fields that ride alongside the pressure division
  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        zero;
    logic        big;
  } side_t;

  localparam int DIV_STAGES = 32;

  localparam s32_t K_128      = 32'sd128;
  localparam s32_t K_8192     = 32'sd8192;
  localparam s32_t K_16384    = 32'sd16384;
  localparam s32_t K_32768    = 32'sd32768;
  localparam s32_t K_64000    = 32'sd64000;
  localparam s32_t K_76800    = 32'sd76800;
  localparam s32_t K_1048576  = 32'sd1048576;
  localparam s32_t K_2097152  = 32'sd2097152;
  localparam s32_t K_HUM_MAX  = 32'sd419430400;
  localparam logic [31:0] K_3125 = 32'd3125;

  function automatic s32_t sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic s32_t zx16(input logic [15:0] v);
    return {16'b0, v};
  endfunction

  function automatic s32_t sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic s32_t zx8(input logic [7:0] v);
    return {24'b0, v};
  endfunction

  function automatic s32_t zx12(input logic [11:0] v);
    return {20'b0, v};
  endfunction

endpackage

// ===== rtl/env_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation: integer temperature, pressure, humidity compensation
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_stall  | adc_temp, adc_press, adc_hum
//   out_    | output    | out_valid/out_stall| temperature, pressure, humidity
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat per cycle sustained while the output is not stalled; 14 setup
// stages, 32 divider stages, 3 correction stages including the output register.
// Rate is set by the fully pipelined bit-per-stage pressure divider.
// Synchronous active-low reset clears all valid bits and calibration.
// A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] in_adc_temp,
  input  logic [19:0] in_adc_press,
  input  logic [15:0] in_adc_hum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_temperature,
  output logic [31:0] out_pressure,
  output logic [16:0] out_humidity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ensc_pkg::*;

  calib_t calib_r;
  logic   en;
  logic   f_vld, d_vld;
  logic [31:0] dvd, dvs, quo, temp_w;
  side_t  f_side, d_side;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP:    calib_r.temp    <= cfg_data[47:0];
        REG_PRESS_A: calib_r.press_a <= cfg_data[47:0];
        REG_PRESS_B: calib_r.press_b <= cfg_data[47:0];
        REG_PRESS_C: calib_r.press_c <= cfg_data[47:0];
        REG_HUM:     calib_r.hum     <= cfg_data;
        default: ;
      endcase
    end
  end

  ensc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .calib    (calib_r),
    .in_vld   (in_valid),
    .adc_temp (in_adc_temp),
    .adc_press(in_adc_press),
    .adc_hum  (in_adc_hum),
    .out_vld  (f_vld),
    .dvd      (dvd),
    .dvs      (dvs),
    .side     (f_side)
  );

  ensc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .dvd     (dvd),
    .dvs     (dvs),
    .side_in (f_side),
    .out_vld (d_vld),
    .quo     (quo),
    .side_out(d_side)
  );

  ensc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .calib      (calib_r),
    .in_vld     (d_vld),
    .quo        (quo),
    .side       (d_side),
    .out_vld    (out_valid),
    .temperature(temp_w),
    .pressure   (out_pressure),
    .humidity   (out_humidity)
  );

  assign out_temperature = $signed(temp_w);

  // checks
  a_stall_map: assert property (@(posedge clk) in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output backpressure");
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pressure)
      && $stable(out_humidity) && $stable(out_temperature))
    else $error("stalled beat changed");
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity <= 17'd102400)
    else $error("humidity out of range");

endmodule

// ===== rtl/ensc_front.sv =====
// ----------------------------------------------------------------------------
// ensc_front: fine temperature, temperature, humidity and pressure setup
// Fourteen register stages, one multiply deep each, ending in the dividend
// and divisor for the pressure division plus the finished side fields.
// ----------------------------------------------------------------------------
module ensc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ensc_pkg::calib_t calib,
  input  logic            in_vld,
  input  logic [19:0]     adc_temp,
  input  logic [19:0]     adc_press,
  input  logic [15:0]     adc_hum,
  output logic            out_vld,
  output logic [31:0]     dvd,
  output logic [31:0]     dvs,
  output ensc_pkg::side_t side
);
  import ensc_pkg::*;

  localparam int NSTG = 14;

  // calibration words
  s32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
  assign t1 = zx16(calib.temp[15:0]);
  assign t2 = sx16(calib.temp[31:16]);
  assign t3 = sx16(calib.temp[47:32]);
  assign p1 = zx16(calib.press_a[15:0]);
  assign p2 = sx16(calib.press_a[31:16]);
  assign p3 = sx16(calib.press_a[47:32]);
  assign p4 = sx16(calib.press_b[15:0]);
  assign p5 = sx16(calib.press_b[31:16]);
  assign p6 = sx16(calib.press_b[47:32]);
  assign h1 = zx8(calib.hum[7:0]);
  assign h2 = sx16(calib.hum[23:8]);
  assign h3 = zx8(calib.hum[31:24]);
  assign h4 = zx12(calib.hum[43:32]);
  assign h5 = zx12(calib.hum[55:44]);
  assign h6 = sx8(calib.hum[63:56]);

  logic [NSTG-1:0] vld_r;

  s32_t at32, ap32, ah32, d1;
  assign at32 = {12'b0, adc_temp};
  assign d1   = (at32 >>> 4) - t1;

  // stage registers
  s32_t s1_ma_r, s1_dd_r, s1_ap_r, s1_ah_r;
  s32_t s2_ma_r, s2_mb_r, s2_ap_r, s2_ah_r;
  s32_t s3_tf_r, s3_ap_r, s3_ah_r;
  s32_t s4_temp_r, s4_v1_r, s4_x_r, s4_ap_r, s4_ah_r;
  s32_t s5_temp_r, s5_qq_r, s5_v1p5_r, s5_p2v1_r, s5_h5x_r, s5_xh6_r, s5_xh3_r;
  s32_t s5_ap_r, s5_ah_r;
  s32_t s6_temp_r, s6_v2a_r, s6_p3_r, s6_v1p5_r, s6_p2v1_r, s6_a0_r, s6_b_r, s6_c_r;
  s32_t s6_ap_r;
  s32_t s7_temp_r, s7_v2b_r, s7_v1b_r, s7_a_r, s7_bc_r, s7_ap_r;
  s32_t s8_temp_r, s8_v2c_r, s8_mv1_r, s8_d_r, s8_a_r, s8_ap_r;
  s32_t s9_temp_r, s9_div_r, s9_n0_r, s9_dh2_r, s9_a_r;
  s32_t s10_temp_r, s10_div_r, s10_e_r, s10_a_r;
  logic [31:0] s10_num_r;
  s32_t s11_temp_r, s11_ae_r;
  logic [31:0] s11_dvd_r, s11_dvs_r;
  logic s11_big_r, s11_zero_r;
  s32_t s12_temp_r, s12_ae_r, s12_ss_r;
  logic [31:0] s12_dvd_r, s12_dvs_r;
  logic s12_big_r, s12_zero_r;
  s32_t s13_temp_r, s13_ae_r, s13_h1_r;
  logic [31:0] s13_dvd_r, s13_dvs_r;
  logic s13_big_r, s13_zero_r;
  logic [31:0] s14_dvd_r, s14_dvs_r;
  side_t s14_side_r;

  s32_t s5_q, s12_s, s14_x;
  assign ap32  = {12'b0, adc_press};
  assign ah32  = {16'b0, adc_hum};
  assign s5_q  = s4_v1_r >>> 2;
  assign s12_s = s11_ae_r >>> 15;
  assign s14_x = s13_ae_r - (s13_h1_r >>> 4);

  // humidity clamp
  s32_t hum_cl;
  always_comb begin
    hum_cl = s14_x;
    if (s14_x < 0) hum_cl = '0;
    if (s14_x > K_HUM_MAX) hum_cl = K_HUM_MAX;
  end

  // valid bits travel with the beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_vld};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // fine temperature
      s1_ma_r <= ((at32 >>> 3) - (t1 <<< 1)) * t2;
      s1_dd_r <= d1 * d1;
      s1_ap_r <= ap32;
      s1_ah_r <= ah32;
      s2_ma_r <= s1_ma_r;
      s2_mb_r <= (s1_dd_r >>> 12) * t3;
      s2_ap_r <= s1_ap_r;
      s2_ah_r <= s1_ah_r;
      s3_tf_r <= (s2_ma_r >>> 11) + (s2_mb_r >>> 14);
      s3_ap_r <= s2_ap_r;
      s3_ah_r <= s2_ah_r;
      // temperature and offsets
      s4_temp_r <= ((s3_tf_r <<< 2) + s3_tf_r + K_128) >>> 8;
      s4_v1_r   <= (s3_tf_r >>> 1) - K_64000;
      s4_x_r    <= s3_tf_r - K_76800;
      s4_ap_r   <= s3_ap_r;
      s4_ah_r   <= s3_ah_r;
      // first products
      s5_temp_r <= s4_temp_r;
      s5_qq_r   <= s5_q * s5_q;
      s5_v1p5_r <= s4_v1_r * p5;
      s5_p2v1_r <= p2 * s4_v1_r;
      s5_h5x_r  <= h5 * s4_x_r;
      s5_xh6_r  <= s4_x_r * h6;
      s5_xh3_r  <= s4_x_r * h3;
      s5_ap_r   <= s4_ap_r;
      s5_ah_r   <= s4_ah_r;
      s6_temp_r <= s5_temp_r;
      s6_v2a_r  <= (s5_qq_r >>> 11) * p6;
      s6_p3_r   <= p3 * (s5_qq_r >>> 13);
      s6_v1p5_r <= s5_v1p5_r;
      s6_p2v1_r <= s5_p2v1_r;
      s6_a0_r   <= (s5_ah_r <<< 14) - (h4 <<< 20) - s5_h5x_r;
      s6_b_r    <= s5_xh6_r >>> 10;
      s6_c_r    <= (s5_xh3_r >>> 11) + K_32768;
      s6_ap_r   <= s5_ap_r;
      s7_temp_r <= s6_temp_r;
      s7_v2b_r  <= s6_v2a_r + (s6_v1p5_r <<< 1);
      s7_v1b_r  <= ((s6_p3_r >>> 3) + (s6_p2v1_r >>> 1)) >>> 18;
      s7_a_r    <= (s6_a0_r + K_16384) >>> 15;
      s7_bc_r   <= s6_b_r * s6_c_r;
      s7_ap_r   <= s6_ap_r;
      s8_temp_r <= s7_temp_r;
      s8_v2c_r  <= (s7_v2b_r >>> 2) + (p4 <<< 16);
      s8_mv1_r  <= (K_32768 + s7_v1b_r) * p1;
      s8_d_r    <= (s7_bc_r >>> 10) + K_2097152;
      s8_a_r    <= s7_a_r;
      s8_ap_r   <= s7_ap_r;
      s9_temp_r <= s8_temp_r;
      s9_div_r  <= s8_mv1_r >>> 15;
      s9_n0_r   <= (K_1048576 - s8_ap_r) - (s8_v2c_r >>> 12);
      s9_dh2_r  <= s8_d_r * h2;
      s9_a_r    <= s8_a_r;
      s10_temp_r <= s9_temp_r;
      s10_div_r  <= s9_div_r;
      s10_num_r  <= s9_n0_r * K_3125;
      s10_e_r    <= (s9_dh2_r + K_8192) >>> 14;
      s10_a_r    <= s9_a_r;
      // division setup, humidity tail
      s11_temp_r <= s10_temp_r;
      s11_ae_r   <= s10_a_r * s10_e_r;
      s11_big_r  <= s10_num_r[31];
      s11_dvd_r  <= s10_num_r[31] ? s10_num_r : {s10_num_r[30:0], 1'b0};
      s11_dvs_r  <= s10_div_r;
      s11_zero_r <= (s10_div_r == 0);
      s12_temp_r <= s11_temp_r;
      s12_ae_r   <= s11_ae_r;
      s12_ss_r   <= s12_s * s12_s;
      s12_dvd_r  <= s11_dvd_r;
      s12_dvs_r  <= s11_dvs_r;
      s12_big_r  <= s11_big_r;
      s12_zero_r <= s11_zero_r;
      s13_temp_r <= s12_temp_r;
      s13_ae_r   <= s12_ae_r;
      s13_h1_r   <= (s12_ss_r >>> 7) * h1;
      s13_dvd_r  <= s12_dvd_r;
      s13_dvs_r  <= s12_dvs_r;
      s13_big_r  <= s12_big_r;
      s13_zero_r <= s12_zero_r;
      s14_dvd_r       <= s13_dvd_r;
      s14_dvs_r       <= s13_dvs_r;
      s14_side_r.temp <= s13_temp_r;
      s14_side_r.hum  <= hum_cl[28:12];
      s14_side_r.zero <= s13_zero_r;
      s14_side_r.big  <= s13_big_r;
    end
  end

  assign out_vld = vld_r[NSTG-1];
  assign dvd     = s14_dvd_r;
  assign dvs     = s14_dvs_r;
  assign side    = s14_side_r;

endmodule

// ===== rtl/ensc_div.sv =====
// ----------------------------------------------------------------------------
// ensc_div: pipelined unsigned 32/32 divider
// Restoring division, one quotient bit per register stage; the side fields
// travel with each beat.
// ----------------------------------------------------------------------------
module ensc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [31:0]     dvd,
  input  logic [31:0]     dvs,
  input  ensc_pkg::side_t side_in,
  output logic            out_vld,
  output logic [31:0]     quo,
  output ensc_pkg::side_t side_out
);
  import ensc_pkg::*;

  logic [DIV_STAGES-1:0] vld_r;
  logic [31:0] rem_r [DIV_STAGES];
  logic [31:0] dq_r  [DIV_STAGES];
  logic [31:0] dvs_r [DIV_STAGES];
  side_t       side_r [DIV_STAGES];

  logic [31:0] rem_nxt [DIV_STAGES];
  logic [31:0] dq_nxt  [DIV_STAGES];

  // one trial subtract per stage
  always_comb begin
    logic [31:0] rs, ds, vs;
    logic [32:0] trial;
    for (int k = 0; k < DIV_STAGES; k++) begin
      rs = (k == 0) ? 32'd0 : rem_r[(k == 0) ? 0 : k - 1];
      ds = (k == 0) ? dvd   : dq_r[(k == 0) ? 0 : k - 1];
      vs = (k == 0) ? dvs   : dvs_r[(k == 0) ? 0 : k - 1];
      trial = {rs, ds[31]};
      if (trial >= {1'b0, vs}) begin
        rem_nxt[k] = 32'(trial - {1'b0, vs});
        dq_nxt[k]  = {ds[30:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[31:0];
        dq_nxt[k]  = {ds[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        dq_r[k]   <= dq_nxt[k];
        dvs_r[k]  <= (k == 0) ? dvs : dvs_r[(k == 0) ? 0 : k - 1];
        side_r[k] <= (k == 0) ? side_in : side_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign quo      = dq_r[DIV_STAGES-1];
  assign side_out = side_r[DIV_STAGES-1];

endmodule

// ===== rtl/ensc_back.sv =====
// ----------------------------------------------------------------------------
// ensc_back: pressure correction and output register
// Three stages after the divider: square and P8 term, P9 term, final sum.
// ----------------------------------------------------------------------------
module ensc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  ensc_pkg::calib_t calib,
  input  logic            in_vld,
  input  logic [31:0]     quo,
  input  ensc_pkg::side_t side,
  output logic            out_vld,
  output logic [31:0]     temperature,
  output logic [31:0]     pressure,
  output logic [16:0]     humidity
);
  import ensc_pkg::*;

  s32_t p7, p8, p9;
  assign p7 = sx16(calib.press_c[15:0]);
  assign p8 = sx16(calib.press_c[31:16]);
  assign p9 = sx16(calib.press_c[47:32]);

  logic [2:0] vld_r;
  logic [31:0] p, p3w;
  assign p   = side.big ? {quo[30:0], 1'b0} : quo;
  assign p3w = {3'b0, p[31:3]};

  logic [31:0] b1_p_r, b1_sq_r, b2_p_r;
  s32_t b1_m8_r, b2_m9_r, b2_v2_r;
  side_t b1_side_r, b2_side_r;
  logic [31:0] temp_r, press_r;
  logic [16:0] hum_r;

  s32_t b1_sqs, p_s, corr;
  assign b1_sqs = {13'b0, b1_sq_r[31:13]};
  assign p_s    = b2_p_r;
  assign corr   = ((b2_m9_r >>> 12) + b2_v2_r + p7) >>> 4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p_r    <= p;
      b1_sq_r   <= p3w * p3w;
      b1_m8_r   <= $signed({2'b0, p[31:2]}) * p8;
      b1_side_r <= side;
      b2_p_r    <= b1_p_r;
      b2_m9_r   <= p9 * b1_sqs;
      b2_v2_r   <= b1_m8_r >>> 13;
      b2_side_r <= b1_side_r;
      // output register
      temp_r  <= b2_side_r.temp;
      hum_r   <= b2_side_r.hum;
      press_r <= b2_side_r.zero ? 32'd0 : 32'(p_s + corr);
    end
  end

  assign out_vld     = vld_r[2];
  assign temperature = temp_r;
  assign pressure    = press_r;
  assign humidity    = hum_r;

endmodule
